[rtl/stpp_pkg.sv]
package stpp_pkg;

   // Spectrum geometry
   localparam int BINS    = 128;
   localparam int BIN_AW  = $clog2(BINS);
   localparam int CNT_W   = $clog2(BINS + 1);

   // Field widths
   localparam int MAG_W   = 16;
   localparam int IDX_W   = 10;
   localparam int BW_W    = 16;
   localparam int FREQ_W  = 26;
   localparam int QUO_W   = 14;
   localparam int RSP_W   = 104;

   localparam logic [BW_W-1:0]   BW_RESET   = 16'd3906;
   localparam logic [FREQ_W-1:0] FREQ_FLOOR = 26'd10000;
   localparam logic [FREQ_W-1:0] STEP_HZ    = 26'd5000;
   localparam logic [12:0]       HALF_STEP  = 13'd2500;

   // x / 5000 == ((x >> 3) * RECIP_625) >> RECIP_SH, exact for x < 2**26
   localparam int                PROD_W    = 47;
   localparam logic [23:0]       RECIP_625 = 24'd13743896;
   localparam int                RECIP_SH  = 33;

   typedef struct packed {
      logic load;
      logic scan;
      logic mul;
      logic order;
      logic div;
      logic qmul;
      logic fin;
   } cmd_type;

   typedef struct packed {
      logic last_acc;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

[rtl/stpp_ram.sv]
module stpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/stpp_ctrl.sv]
module stpp_ctrl
   import stpp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_SEARCH = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_ORDER  = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_QMUL   = 7'b0100000,
      ST_FIN    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.last_acc) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            cmd.order = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div  = 1'b1;
            state_in = ST_QMUL;
         end
         ST_QMUL: begin
            cmd.qmul = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (sts.out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/stpp_dp.sv]
module stpp_dp
   import stpp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [MAG_W-1:0] req_tdata,
   input  logic             req_tlast,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [BW_W-1:0]  csr_data,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [BW_W-1:0]   bw_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [MAG_W-1:0]  best_val_ff;
   logic [BIN_AW-1:0] best_idx_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic              rd_vld_ff;
   logic [BIN_AW-1:0] rd_idx_ff;
   logic [MAG_W-1:0]  sc_val_ff;
   logic [BIN_AW-1:0] sc_idx_ff;
   logic [FREQ_W-1:0] fa_ff, fb_ff, hi_ff, lo_ff;
   logic [QUO_W-1:0]  qh_ff, ql_ff;
   logic [FREQ_W-1:0] mh_ff, ml_ff;
   logic              rsp_vld_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic              acc, store_en, issue, suppress;
   logic [MAG_W-1:0]  rd_data, cand;
   logic [PROD_W-1:0] ph, pl;
   logic [FREQ_W-1:0] rh, rl, rnd_h, rnd_l;

   assign req_tready = cmd.load;
   assign csr_ready  = 1'b1;
   assign acc        = req_tvalid && cmd.load;
   assign store_en   = acc && (count_ff < CNT_W'(BINS));
   assign issue      = cmd.scan && (scan_ff < count_ff);

   assign sts.last_acc  = acc && req_tlast;
   assign sts.scan_done = !(scan_ff < count_ff) && !rd_vld_ff;
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

   stpp_ram #(
      .WIDTH(MAG_W),
      .DEPTH(BINS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (count_ff[BIN_AW-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (scan_ff[BIN_AW-1:0]),
      .rd_data (rd_data)
   );

   // peak bin and the bin below it read as cleared
   assign suppress = (rd_idx_ff == best_idx_ff) ||
                     ((best_idx_ff != '0) && (rd_idx_ff == best_idx_ff - BIN_AW'(1)));
   assign cand     = suppress ? '0 : rd_data;

   assign ph = (PROD_W'(hi_ff >> 3)) * PROD_W'(RECIP_625);
   assign pl = (PROD_W'(lo_ff >> 3)) * PROD_W'(RECIP_625);

   assign rh    = hi_ff - mh_ff;
   assign rl    = lo_ff - ml_ff;
   assign rnd_h = mh_ff + ((rh > FREQ_W'(HALF_STEP)) ? STEP_HZ : '0);
   assign rnd_l = ml_ff + ((rl > FREQ_W'(HALF_STEP)) ? STEP_HZ : '0);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff       <= BW_RESET;
         count_ff    <= '0;
         best_val_ff <= '0;
         best_idx_ff <= '0;
         scan_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_valid) bw_ff <= csr_data;
         if (store_en) begin
            count_ff <= count_ff + CNT_W'(1);
            if ((count_ff != '0) && (req_tdata > best_val_ff)) begin
               best_val_ff <= req_tdata;
               best_idx_ff <= count_ff[BIN_AW-1:0];
            end
         end
         if (sts.last_acc) begin
            scan_ff <= CNT_W'(1);
         end else if (issue) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end
         rd_vld_ff <= issue;
         if (cmd.fin) begin
            count_ff    <= '0;
            best_val_ff <= '0;
            best_idx_ff <= '0;
            rsp_vld_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (issue) rd_idx_ff <= scan_ff[BIN_AW-1:0];
      if (sts.last_acc) begin
         sc_val_ff <= '0;
         sc_idx_ff <= '0;
      end else if (rd_vld_ff && (cand > sc_val_ff)) begin
         sc_val_ff <= cand;
         sc_idx_ff <= rd_idx_ff;
      end
      if (cmd.mul) begin
         fa_ff <= FREQ_W'(bw_ff) * FREQ_W'(best_idx_ff);
         fb_ff <= FREQ_W'(bw_ff) * FREQ_W'(sc_idx_ff);
      end
      if (cmd.order) begin
         hi_ff <= (fa_ff < fb_ff) ? fb_ff : fa_ff;
         if (((fa_ff < fb_ff) ? fa_ff : fb_ff) < FREQ_FLOOR) begin
            lo_ff <= (fa_ff < fb_ff) ? fb_ff : fa_ff;
         end else begin
            lo_ff <= (fa_ff < fb_ff) ? fa_ff : fb_ff;
         end
      end
      if (cmd.div) begin
         qh_ff <= QUO_W'(ph >> RECIP_SH);
         ql_ff <= QUO_W'(pl >> RECIP_SH);
      end
      if (cmd.qmul) begin
         mh_ff <= FREQ_W'(qh_ff) * STEP_HZ;
         ml_ff <= FREQ_W'(ql_ff) * STEP_HZ;
      end
      if (cmd.fin) begin
         rsp_data_ff <= {rnd_l, rnd_h, IDX_W'(sc_idx_ff), sc_val_ff,
                         IDX_W'(best_idx_ff), best_val_ff};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/spectrum_top_two_peak_picker_unit.sv]
// Throughput: one bin transaction per cycle while a frame loads; the input is
// held off from the last bin until the frame's result has been registered.
// Sequence: after the last bin the bin store is scanned for the second peak (a
// frame holds at most 128 stored bins), then MUL, ORDER, DIV and QMUL run;
// rsp_tvalid rises once FIN registers the result, and FIN waits while the previous result is held.
// Reset (synchronous, active high): empty frame, no result, bin width 3906 Hz.
module spectrum_top_two_peak_picker_unit
   import stpp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // bin input channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [MAG_W-1:0] req_tdata,   // [15:0] magnitude
   input  logic             req_tlast,   // last_bin
   // bin width register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [BW_W-1:0]  csr_data,    // [15:0] bin_width_hz
   // result channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [15:0] peak_value, [25:16] peak_bin,
                                         // [41:26] second_value, [51:42] second_bin,
                                         // [77:52] freq_high_hz, [103:78] freq_low_hz
);

   // The controller walks LOAD -> SEARCH -> MUL -> ORDER -> DIV -> QMUL -> FIN.
   // The first maximum is tracked as bins stream in; the second is found by a
   // scan of the bin store with the peak bin and its lower neighbor masked.
   // The result sits in an output register, so the next frame may load while
   // it waits; FIN only holds if that register is still full.
   cmd_type cmd;
   sts_type sts;

   stpp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   stpp_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
